// ----- rtl/m16x_pkg.sv -----
// m16x_pkg: shared types, codes and encoding helpers for the mips16e extended
// instruction translator. no dependencies.
package m16x_pkg;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_DIRECT = 2'd1;
    localparam logic [1:0] KIND_RSVD   = 2'd2;

    localparam logic [2:0] DOP_PC_ADD  = 3'd0;
    localparam logic [2:0] DOP_BRANCH  = 3'd1;
    localparam logic [2:0] DOP_BEQZ    = 3'd2;
    localparam logic [2:0] DOP_BNEZ    = 3'd3;
    localparam logic [2:0] DOP_PC_LOAD = 3'd4;

    localparam logic [5:0] OP_ADDIU  = 6'h09;
    localparam logic [5:0] OP_SLTI   = 6'h0A;
    localparam logic [5:0] OP_SLTIU  = 6'h0B;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_XORI   = 6'h0E;
    localparam logic [5:0] OP_DADDIU = 6'h19;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LH     = 6'h21;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_LBU    = 6'h24;
    localparam logic [5:0] OP_LHU    = 6'h25;
    localparam logic [5:0] OP_LWU    = 6'h27;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SH     = 6'h29;
    localparam logic [5:0] OP_SW     = 6'h2B;
    localparam logic [5:0] OP_LD     = 6'h37;
    localparam logic [5:0] OP_SD     = 6'h3F;

    localparam logic [5:0] FN_SLL    = 6'h00;
    localparam logic [5:0] FN_SRL    = 6'h02;
    localparam logic [5:0] FN_SRA    = 6'h03;
    localparam logic [5:0] FN_DSLL   = 6'h38;
    localparam logic [5:0] FN_DSRL   = 6'h3A;
    localparam logic [5:0] FN_DSRA   = 6'h3B;
    localparam logic [5:0] FN_DSLL32 = 6'h3C;
    localparam logic [5:0] FN_DSRL32 = 6'h3E;
    localparam logic [5:0] FN_DSRA32 = 6'h3F;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_SP   = 5'd29;
    localparam logic [4:0] REG_T    = 5'd24;
    localparam logic [4:0] REG_RA   = 5'd31;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] mips_word;
        logic [2:0]  direct_op;
        logic [4:0]  dest_reg;
        logic [4:0]  test_reg;
        logic [31:0] target_addr;
        logic        block_end;
    } t_result;

    function automatic logic [4:0] map3(input logic [2:0] f);
        map3 = (f[2:1] == 2'b00) ? {2'b10, f} : {2'b00, f};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        enc_i = {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sa, input logic [5:0] fn);
        enc_r = {6'd0, 5'd0, rt, rd, sa, fn};
    endfunction

    // six-bit amount, upper bit picks the *32 funct
    function automatic logic [31:0] enc_dshift(input logic [4:0] rt, input logic [4:0] rd,
                                               input logic [5:0] sh, input logic [5:0] fn,
                                               input logic [5:0] fn32);
        enc_dshift = enc_r(rt, rd, sh[4:0], sh[5] ? fn32 : fn);
    endfunction

endpackage

// ----- rtl/m16x_decode.sv -----
// m16x_decode: combinational decode of one extend/instruction halfword pair
// into a translated word, a direct op or reserved. depends on m16x_pkg.
module m16x_decode (
    input  logic [15:0]      i_extend_half,
    input  logic [15:0]      i_insn_half,
    input  logic [31:0]      i_insn_pc,
    input  logic [31:0]      i_base_addr,
    input  logic             i_allow_64bit,
    output m16x_pkg::t_result o_result
);
    import m16x_pkg::*;

    localparam logic [4:0] MJ_ADDIUSP = 5'h00;
    localparam logic [4:0] MJ_ADDIUPC = 5'h01;
    localparam logic [4:0] MJ_B       = 5'h02;
    localparam logic [4:0] MJ_BEQZ    = 5'h04;
    localparam logic [4:0] MJ_BNEZ    = 5'h05;
    localparam logic [4:0] MJ_SHIFT   = 5'h06;
    localparam logic [4:0] MJ_LD      = 5'h07;
    localparam logic [4:0] MJ_RRIA    = 5'h08;
    localparam logic [4:0] MJ_ADDIU8  = 5'h09;
    localparam logic [4:0] MJ_SLTI    = 5'h0A;
    localparam logic [4:0] MJ_SLTIU   = 5'h0B;
    localparam logic [4:0] MJ_I8      = 5'h0C;
    localparam logic [4:0] MJ_LI      = 5'h0D;
    localparam logic [4:0] MJ_CMPI    = 5'h0E;
    localparam logic [4:0] MJ_SD      = 5'h0F;
    localparam logic [4:0] MJ_LB      = 5'h10;
    localparam logic [4:0] MJ_LH      = 5'h11;
    localparam logic [4:0] MJ_LWSP    = 5'h12;
    localparam logic [4:0] MJ_LW      = 5'h13;
    localparam logic [4:0] MJ_LBU     = 5'h14;
    localparam logic [4:0] MJ_LHU     = 5'h15;
    localparam logic [4:0] MJ_LWPC    = 5'h16;
    localparam logic [4:0] MJ_LWU     = 5'h17;
    localparam logic [4:0] MJ_SB      = 5'h18;
    localparam logic [4:0] MJ_SH      = 5'h19;
    localparam logic [4:0] MJ_SWSP    = 5'h1A;
    localparam logic [4:0] MJ_SW      = 5'h1B;
    localparam logic [4:0] MJ_RR      = 5'h1D;
    localparam logic [4:0] MJ_I64     = 5'h1F;

    localparam logic [1:0] SH_SLL  = 2'd0;
    localparam logic [1:0] SH_DSLL = 2'd1;
    localparam logic [1:0] SH_SRL  = 2'd2;
    localparam logic [1:0] SH_SRA  = 2'd3;

    localparam logic [2:0] I8_BTEQZ = 3'd0;
    localparam logic [2:0] I8_BTNEZ = 3'd1;
    localparam logic [2:0] I8_SWRA  = 3'd2;
    localparam logic [2:0] I8_ADJSP = 3'd3;

    localparam logic [2:0] I64_SDSP    = 3'd1;
    localparam logic [2:0] I64_SDRA    = 3'd2;
    localparam logic [2:0] I64_DADJSP  = 3'd3;
    localparam logic [2:0] I64_DADDIU5 = 3'd5;
    localparam logic [2:0] I64_DADDIUPC = 3'd6;
    localparam logic [2:0] I64_DADDIUSP = 3'd7;

    localparam logic [4:0] RR_DSRL = 5'h08;
    localparam logic [4:0] RR_DSRA = 5'h13;

    logic [4:0]  op;
    logic [2:0]  sub;
    logic [4:0]  rx;
    logic [4:0]  ry;
    logic [15:0] imm16;
    logic [14:0] imm15;
    logic [15:0] imm_rria;
    logic [31:0] brt;
    logic [31:0] pcrel;
    logic [4:0]  sa5;
    logic        s5;
    logic [5:0]  sh6;
    logic        x64;
    logic        syn;
    logic [31:0] w;
    t_result     res;

    assign op       = i_insn_half[15:11];
    assign sub      = i_insn_half[10:8];
    assign rx       = map3(i_insn_half[10:8]);
    assign ry       = map3(i_insn_half[7:5]);
    assign imm16    = {i_extend_half[4:0], i_extend_half[10:5], i_insn_half[4:0]};
    assign imm15    = {i_extend_half[3:0], i_extend_half[10:4], i_insn_half[3:0]};
    assign imm_rria = {imm15[14], imm15};
    assign brt      = i_insn_pc + 32'd4 + {{15{imm16[15]}}, imm16, 1'b0};
    assign pcrel    = {i_base_addr[31:2], 2'b00} + {{16{imm16[15]}}, imm16};
    assign sa5      = i_extend_half[10:6];
    assign s5       = i_extend_half[5];
    assign sh6      = {i_extend_half[5], i_extend_half[10:6]};
    assign x64      = i_allow_64bit;

    always_comb begin
        res      = '0;
        res.kind = KIND_RSVD;
        syn      = 1'b0;
        w        = '0;
        unique case (op)
            MJ_ADDIUSP: begin
                w = enc_i(OP_ADDIU, REG_SP, rx, imm16); syn = 1'b1;
            end
            MJ_ADDIUPC: begin
                res.kind = KIND_DIRECT; res.direct_op = DOP_PC_ADD;
                res.dest_reg = rx; res.target_addr = pcrel;
            end
            MJ_B: begin
                res.kind = KIND_DIRECT; res.direct_op = DOP_BRANCH;
                res.target_addr = brt; res.block_end = 1'b1;
            end
            MJ_BEQZ, MJ_BNEZ: begin
                res.kind = KIND_DIRECT;
                res.direct_op = (op == MJ_BEQZ) ? DOP_BEQZ : DOP_BNEZ;
                res.test_reg = rx; res.target_addr = brt; res.block_end = 1'b1;
            end
            MJ_SHIFT: begin
                unique case (i_insn_half[1:0])
                    SH_SLL: begin
                        if (!s5) begin w = enc_r(ry, rx, sa5, FN_SLL); syn = 1'b1; end
                    end
                    SH_DSLL: begin
                        if (x64) begin
                            w = enc_dshift(ry, rx, sh6, FN_DSLL, FN_DSLL32); syn = 1'b1;
                        end
                    end
                    SH_SRL: begin
                        if (!s5) begin w = enc_r(ry, rx, sa5, FN_SRL); syn = 1'b1; end
                    end
                    SH_SRA: begin
                        if (!s5) begin w = enc_r(ry, rx, sa5, FN_SRA); syn = 1'b1; end
                    end
                endcase
            end
            MJ_LD: begin
                if (x64) begin w = enc_i(OP_LD, rx, ry, imm16); syn = 1'b1; end
            end
            MJ_RRIA: begin
                if (i_insn_half[4]) begin
                    if (x64) begin w = enc_i(OP_DADDIU, rx, ry, imm_rria); syn = 1'b1; end
                end else begin
                    w = enc_i(OP_ADDIU, rx, ry, imm_rria); syn = 1'b1;
                end
            end
            MJ_ADDIU8: begin w = enc_i(OP_ADDIU, rx, rx, imm16); syn = 1'b1; end
            MJ_SLTI:   begin w = enc_i(OP_SLTI, rx, REG_T, imm16); syn = 1'b1; end
            MJ_SLTIU:  begin w = enc_i(OP_SLTIU, rx, REG_T, imm16); syn = 1'b1; end
            MJ_I8: begin
                unique case (sub)
                    I8_BTEQZ, I8_BTNEZ: begin
                        res.kind = KIND_DIRECT;
                        res.direct_op = (sub == I8_BTEQZ) ? DOP_BEQZ : DOP_BNEZ;
                        res.test_reg = REG_T; res.target_addr = brt; res.block_end = 1'b1;
                    end
                    I8_SWRA: begin w = enc_i(OP_SW, REG_SP, REG_RA, imm16); syn = 1'b1; end
                    I8_ADJSP: begin
                        w = enc_i(OP_ADDIU, REG_SP, REG_SP, imm16); syn = 1'b1;
                    end
                    default: ;
                endcase
            end
            MJ_LI:   begin w = enc_i(OP_ORI, REG_ZERO, rx, imm16); syn = 1'b1; end
            MJ_CMPI: begin w = enc_i(OP_XORI, rx, REG_T, imm16); syn = 1'b1; end
            MJ_SD: begin
                if (x64) begin w = enc_i(OP_SD, rx, ry, imm16); syn = 1'b1; end
            end
            MJ_LB:   begin w = enc_i(OP_LB, rx, ry, imm16); syn = 1'b1; end
            MJ_LH:   begin w = enc_i(OP_LH, rx, ry, imm16); syn = 1'b1; end
            MJ_LWSP: begin w = enc_i(OP_LW, REG_SP, rx, imm16); syn = 1'b1; end
            MJ_LW:   begin w = enc_i(OP_LW, rx, ry, imm16); syn = 1'b1; end
            MJ_LBU:  begin w = enc_i(OP_LBU, rx, ry, imm16); syn = 1'b1; end
            MJ_LHU:  begin w = enc_i(OP_LHU, rx, ry, imm16); syn = 1'b1; end
            MJ_LWPC: begin
                res.kind = KIND_DIRECT; res.direct_op = DOP_PC_LOAD;
                res.dest_reg = rx; res.target_addr = pcrel;
            end
            MJ_LWU: begin
                if (x64) begin w = enc_i(OP_LWU, rx, ry, imm16); syn = 1'b1; end
            end
            MJ_SB:   begin w = enc_i(OP_SB, rx, ry, imm16); syn = 1'b1; end
            MJ_SH:   begin w = enc_i(OP_SH, rx, ry, imm16); syn = 1'b1; end
            MJ_SWSP: begin w = enc_i(OP_SW, REG_SP, rx, imm16); syn = 1'b1; end
            MJ_SW:   begin w = enc_i(OP_SW, rx, ry, imm16); syn = 1'b1; end
            MJ_RR: begin
                if (x64 && sub == 3'd0) begin
                    if (i_insn_half[4:0] == RR_DSRL) begin
                        w = enc_dshift(ry, ry, sh6, FN_DSRL, FN_DSRL32); syn = 1'b1;
                    end else if (i_insn_half[4:0] == RR_DSRA) begin
                        w = enc_dshift(ry, ry, sh6, FN_DSRA, FN_DSRA32); syn = 1'b1;
                    end
                end
            end
            MJ_I64: begin
                if (x64) begin
                    unique case (sub)
                        I64_SDSP: begin
                            w = enc_i(OP_SD, REG_SP, ry, imm16); syn = 1'b1;
                        end
                        I64_SDRA: begin
                            w = enc_i(OP_SD, REG_SP, REG_RA, imm16); syn = 1'b1;
                        end
                        I64_DADJSP: begin
                            w = enc_i(OP_DADDIU, REG_SP, REG_SP, imm16); syn = 1'b1;
                        end
                        I64_DADDIU5: begin
                            w = enc_i(OP_DADDIU, ry, ry, imm16); syn = 1'b1;
                        end
                        I64_DADDIUPC: begin
                            res.kind = KIND_DIRECT; res.direct_op = DOP_PC_ADD;
                            res.dest_reg = ry; res.target_addr = pcrel;
                        end
                        I64_DADDIUSP: begin
                            w = enc_i(OP_DADDIU, REG_SP, ry, imm16); syn = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (syn) begin
            res.kind      = KIND_WORD;
            res.mips_word = w;
        end
    end

    assign o_result = res;

endmodule

// ----- rtl/mips16_extended_insn_translator_top.sv -----
// mips16_extended_insn_translator_top: request register, decode, result register.
// depends on m16x_pkg and m16x_decode.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-----------------------------------
//  request   | in        | start, busy             | i_extend_half i_insn_half i_insn_pc
//            |           |                         | i_base_addr
//  result    | out       | o_done (one-cycle pulse)| o_kind o_mips_word o_direct_op
//            |           |                         | o_dest_reg o_test_reg o_target_addr
//            |           |                         | o_block_end
//  config    | in        | i_cfg_wr_en             | i_cfg_wr_data (allow_64bit)
//
// one request per cycle; busy stays low, the pipeline never fills up.
// each request gives one result: it is held in the request register, then passes
// through decode into the result register.
// synchronous active-low reset clears the valid bits and allow_64bit.
// the receiver cannot stall; results leave on the cycle they are shown.
module mips16_extended_insn_translator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_extend_half,
    input  logic [15:0] i_insn_half,
    input  logic [31:0] i_insn_pc,
    input  logic [31:0] i_base_addr,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    output logic        o_done,
    output logic [1:0]  o_kind,
    output logic [31:0] o_mips_word,
    output logic [2:0]  o_direct_op,
    output logic [4:0]  o_dest_reg,
    output logic [4:0]  o_test_reg,
    output logic [31:0] o_target_addr,
    output logic        o_block_end
);
    import m16x_pkg::*;

    logic        r_allow_64bit;
    logic        r_in_valid;
    logic [15:0] r_extend;
    logic [15:0] r_insn;
    logic [31:0] r_pc;
    logic [31:0] r_base;
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_64bit <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_allow_64bit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_extend <= i_extend_half;
            r_insn   <= i_insn_half;
            r_pc     <= i_insn_pc;
            r_base   <= i_base_addr;
        end
        if (r_in_valid) begin
            r_res <= n_res;
        end
    end

    m16x_decode u_decode (
        .i_extend_half (r_extend),
        .i_insn_half   (r_insn),
        .i_insn_pc     (r_pc),
        .i_base_addr   (r_base),
        .i_allow_64bit (r_allow_64bit),
        .o_result      (n_res)
    );

    assign o_done        = r_out_valid;
    assign o_kind        = r_res.kind;
    assign o_mips_word   = r_res.mips_word;
    assign o_direct_op   = r_res.direct_op;
    assign o_dest_reg    = r_res.dest_reg;
    assign o_test_reg    = r_res.test_reg;
    assign o_target_addr = r_res.target_addr;
    assign o_block_end   = r_res.block_end;

    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 2))
        else $error("result without a request two cycles earlier");

    a_word_has_no_direct_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_kind == KIND_WORD |->
            o_target_addr == 32'd0 && !o_block_end && o_dest_reg == 5'd0 &&
            o_test_reg == 5'd0)
        else $error("translated word carries direct-op fields");

    a_end_only_on_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_block_end |->
            o_kind == KIND_DIRECT &&
            (o_direct_op == DOP_BRANCH || o_direct_op == DOP_BEQZ ||
             o_direct_op == DOP_BNEZ))
        else $error("end of block flagged on a non-branch");

    a_no_dword_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_kind == KIND_WORD && !r_allow_64bit |->
            o_mips_word[31:26] != OP_LD && o_mips_word[31:26] != OP_SD &&
            o_mips_word[31:26] != OP_DADDIU && o_mips_word[31:26] != OP_LWU)
        else $error("doubleword instruction produced with 64-bit support off");

endmodule
